@@ hdl/bel_pkg.sv @@
// Package for the breakpoint envelope: types, constants and state codes.
// No dependencies.
package bel_pkg;

    localparam int MAX_POINTS_DEF = 16;

    // Register indexes.
    localparam logic [2:0] REG_NUM_POINTS = 3'd0;
    localparam logic [2:0] REG_RATE       = 3'd1;
    localparam logic [2:0] REG_SYNC       = 3'd2;
    localparam logic [2:0] REG_BIPOLAR    = 3'd3;
    localparam logic [2:0] REG_AMOUNT     = 3'd4;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_HELD   = 2'd2;
    localparam logic [1:0] ST_ZERO   = 2'd3;

    localparam logic signed [17:0] CURVE_K = 18'sd45875;

    typedef struct packed {
        logic                func;
        logic [3:0]          point_index;
        logic [14:0]         point_x;
        logic [14:0]         point_y;
        logic signed [15:0]  point_curve;
        logic signed [31:0]  transport_pos;
        logic [31:0]         free_time;
    } bel_in_t;

    typedef struct packed {
        logic signed [18:0] mod_value;
        logic [3:0]         segment_used;
        logic [1:0]         status;
    } bel_out_t;

    typedef enum logic [3:0] {
        S_IDLE, S_PHASE, S_WALK, S_DIVIDE, S_LIN, S_BEND, S_CURVE1, S_CURVE2,
        S_BIPOLAR, S_SCALE, S_OUT
    } bel_state_t;

endpackage

@@ hdl/bel_if.sv @@
// Valid/ready channel interface carrying one payload.
// No dependencies; the payload type is a parameter.
interface bel_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/bel_divider.sv @@
// Restoring divider, one quotient bit per cycle, signed operands.
// Depends on bel_pkg.
module bel_divider
    import bel_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [30:0] num,
    input  logic signed [15:0] den,
    output logic               done,
    output logic signed [31:0] quo
);
    logic [30:0] rem_reg, rem_next;
    logic [30:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic [14:0] den_reg, den_next;
    logic [15:0] trial;
    logic [31:0] qext;

    // Shift one numerator bit into the partial remainder per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        den_next  = den_reg;
        trial     = {rem_reg[14:0], q_reg[30]};
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = '0;
            q_next    = num[30] ? 31'(-num) : num;
            neg_next  = num[30] ^ den[15];
            den_next  = den[15] ? 15'(-den) : den[14:0];
            cnt_next  = 5'd31;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[29:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = 31'(trial - {1'b0, den_reg});
                q_next[0] = 1'b1;
            end
            else
                rem_next = 31'(trial);
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        den_reg <= den_next;
    end

    // Quotient truncates toward zero; done is high while no division runs.
    assign qext = {1'b0, q_reg};
    assign quo  = neg_reg ? -$signed(qext) : $signed(qext);
    assign done = !busy_reg;
endmodule

@@ hdl/breakpoint_envelope_lfo.sv @@
// Breakpoint envelope LFO: point table writes and envelope evaluation.
// Writes can follow back to back. An evaluate goes through the phase step, table walk,
// serial divide and five multiply steps when interpolating; a zero-width segment skips
// the divide, a phase past the last point goes from the walk to the bipolar, scale and
// output steps, and a table of one point or none skips the walk. ready is low while an
// item is in work; reset sets registers and three points at one half.
module breakpoint_envelope_lfo
    import bel_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    bel_if.sink         in_ch,
    bel_if.source       out_ch
);
    localparam int IW = $clog2(MAX_POINTS);

    logic [14:0]        px_reg [MAX_POINTS];
    logic [14:0]        py_reg [MAX_POINTS];
    logic signed [15:0] pc_reg [MAX_POINTS];

    logic [4:0]         num_reg;
    logic [23:0]        rate_reg;
    logic               sync_reg, bip_reg;
    logic signed [15:0] amt_reg;

    bel_state_t state_reg, state_next;
    bel_in_t    item_reg;
    logic [IW:0] idx_reg, idx_next;
    logic [IW:0] n_reg;
    logic [13:0] phase_reg;
    logic signed [31:0] t_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] v_reg;
    logic [3:0]  seg_reg;
    logic [1:0]  st_reg;
    bel_out_t    res_reg;
    logic signed [31:0] mop_a, mop_b;
    logic signed [63:0] mprod;
    logic [IW-1:0] ia, ib;
    logic [31:0] pos;
    logic [IW:0] n_lim;
    logic signed [31:0] t_sat;
    logic signed [63:0] scaled;

    // Serial divider shared across evaluates.
    logic div_start, div_done;
    logic signed [31:0] div_q;
    logic signed [30:0] div_num;
    logic signed [15:0] div_den;

    bel_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_q)
    );

    assign ia = idx_reg[IW-1:0];
    assign ib = IW'(idx_reg + 1'b1);
    assign n_lim = (32'(num_reg) > 32'(MAX_POINTS)) ? (IW+1)'(MAX_POINTS)
                                                    : (IW+1)'(num_reg);
    assign pos = (sync_reg && !item_reg.transport_pos[31]) ? item_reg.transport_pos
                                                           : item_reg.free_time;

    // Shared multiplier: operands chosen by state.
    always_comb
    begin
        mop_a = '0;
        mop_b = '0;
        case (state_reg)
            S_LIN:    begin mop_a = t_reg;
                          mop_b = 32'($signed({1'b0, py_reg[ib]}) - $signed({1'b0, py_reg[ia]}));
                      end
            S_BEND:   begin mop_a = t_reg; mop_b = 32'sd16384 - t_reg; end
            S_CURVE1: begin mop_a = 32'(pc_reg[ib]); mop_b = 32'(CURVE_K); end
            S_CURVE2: begin mop_a = t_reg; mop_b = 32'(acc_reg); end
            S_SCALE:  begin mop_a = v_reg; mop_b = 32'(amt_reg); end
            default:  begin mop_a = '0; mop_b = '0; end
        endcase
    end
    assign mprod = mop_a * mop_b;

    assign div_num = 31'($signed({1'b0, phase_reg}) - $signed({1'b0, px_reg[ia]})) <<< 14;
    assign div_den = 16'($signed({1'b0, px_reg[ib]}) - $signed({1'b0, px_reg[ia]}));
    assign div_start = (state_reg == S_WALK) && !(idx_reg + 1'b1 < n_reg
                        && px_reg[ib] <= {1'b0, phase_reg}) && (idx_reg + 1'b1 < n_reg)
                        && (div_den != '0);
    assign t_sat = (div_q > 32'sd131071) ? 32'sd131071 :
                   (div_q < -32'sd131072) ? -32'sd131072 : div_q;
    assign scaled = mprod >>> 14;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
                if (in_ch.valid && in_ch.data.func == FUNC_EVAL)
                    state_next = S_PHASE;
            S_PHASE:
                if (n_lim <= (IW+1)'(1))
                    state_next = S_BIPOLAR;
                else
                begin
                    state_next = S_WALK;
                    idx_next   = '0;
                end
            S_WALK:
                if (idx_reg + 1'b1 < n_reg && px_reg[ib] <= {1'b0, phase_reg})
                    idx_next = idx_reg + 1'b1;
                else if (idx_reg + 1'b1 >= n_reg)
                    state_next = S_BIPOLAR;
                else if (div_den == '0)
                    state_next = S_LIN;
                else
                    state_next = S_DIVIDE;
            S_DIVIDE:
                if (div_done)
                    state_next = S_LIN;
            S_LIN:     state_next = S_BEND;
            S_BEND:    state_next = S_CURVE1;
            S_CURVE1:  state_next = S_CURVE2;
            S_CURVE2:  state_next = S_BIPOLAR;
            S_BIPOLAR: state_next = S_SCALE;
            S_SCALE:   state_next = S_OUT;
            S_OUT:
                if (out_ch.ready)
                    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data  = res_reg;

    // Hold configuration, the point table and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            num_reg   <= 5'd3;
            rate_reg  <= 24'd65536;
            sync_reg  <= 1'b0;
            bip_reg   <= 1'b0;
            amt_reg   <= 16'sd16384;
            for (int k = 0; k < MAX_POINTS; k++)
            begin
                px_reg[k] <= (k < 3) ? 15'(k * 8192) : '0;
                py_reg[k] <= (k < 3) ? 15'd8192 : '0;
                pc_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_POINTS: num_reg  <= cfg_data[4:0];
                    REG_RATE:       rate_reg <= cfg_data;
                    REG_SYNC:       sync_reg <= cfg_data[0];
                    REG_BIPOLAR:    bip_reg  <= cfg_data[0];
                    REG_AMOUNT:     amt_reg  <= cfg_data[15:0];
                    default:        ;
                endcase
            end
            if (in_ch.valid && in_ch.ready && in_ch.data.func == FUNC_WRITE
                && 32'(in_ch.data.point_index) < MAX_POINTS)
            begin
                px_reg[IW'(in_ch.data.point_index)] <= in_ch.data.point_x;
                py_reg[IW'(in_ch.data.point_index)] <= in_ch.data.point_y;
                pc_reg[IW'(in_ch.data.point_index)] <= in_ch.data.point_curve;
            end
        end
    end

    // Advance the datapath.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        case (state_reg)
            S_IDLE:
                if (in_ch.valid)
                    item_reg <= in_ch.data;
            S_PHASE:
            begin
                phase_reg <= 14'((56'(pos) * 56'(rate_reg)) >> 18);
                n_reg     <= n_lim;
                seg_reg   <= '0;
                st_reg    <= ST_SINGLE;
                v_reg     <= (n_lim == '0) ? 32'sd8192 : 32'(py_reg[0]);
            end
            S_WALK:
                if (idx_reg + 1'b1 >= n_reg)
                begin
                    v_reg   <= 32'(py_reg[ia]);
                    seg_reg <= 4'(idx_reg);
                    st_reg  <= ST_HELD;
                end
                else if (!(px_reg[ib] <= {1'b0, phase_reg}))
                begin
                    seg_reg <= 4'(idx_reg);
                    st_reg  <= (div_den == '0) ? ST_ZERO : ST_INTERP;
                    t_reg   <= '0;
                end
            S_DIVIDE:
                if (div_done)
                    t_reg <= t_sat;
            S_LIN:
                v_reg <= 32'(py_reg[ia]) + 32'(mprod >>> 14);
            S_BEND:
                acc_reg <= mprod >>> 14;
            S_CURVE1:
                t_reg <= 32'(mprod);
            S_CURVE2:
                v_reg <= v_reg + 32'(mprod >>> 30);
            S_BIPOLAR:
                if (bip_reg)
                    v_reg <= (v_reg <<< 1) - 32'sd16384;
            S_SCALE:
            begin
                res_reg.mod_value    <= (scaled > 64'sd262143) ? 19'sd262143 :
                                        (scaled < -64'sd262144) ? -19'sd262144 : 19'(scaled);
                res_reg.segment_used <= seg_reg;
                res_reg.status       <= st_reg;
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result dropped");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> state_reg == S_WALK) else $error("divide started out of walk");
`endif
endmodule
